@@ sv/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    // Defaults for the top level parameters.
    localparam int DEPTH_DEF     = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int PRIO_BITS_DEF = 16;

    // Fixed field widths on the ports.
    localparam int FUNC_W   = 3;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Stream word layout.
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 24;
    localparam int M_HV_BIT   = 2;
    localparam int M_HEAD_LSB = 3;
    localparam int M_OCC_LSB  = 19;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FRONT   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_NUDGE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   item_id;
        logic [PRIO_W-1:0] item_priority;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                head_valid;
        logic [ID_W-1:0]     head_id;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

endpackage

`default_nettype wire

@@ sv/spq_slot_ram.sv @@
`default_nettype none

module spq_slot_ram #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF,
    parameter int WIDTH = spq_pkg::ID_BITS_DEF + spq_pkg::PRIO_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/spq_seq.sv @@
`default_nettype none

module spq_seq #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int EW = ID_BITS + PRIO_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cmd_valid,
    input  wire spq_pkg::cmd_t    cmd,
    output logic                  cmd_ready,
    input  wire logic             out_free,
    output logic                  res_valid,
    output spq_pkg::result_t      res,
    output logic                  ram_wr_en,
    output logic [AW-1:0]         ram_wr_addr,
    output logic [EW-1:0]         ram_wr_data,
    output logic                  ram_rd_en,
    output logic [AW-1:0]         ram_rd_addr,
    input  wire logic [EW-1:0]    ram_rd_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (ID_BITS > PRIO_BITS) ? ID_BITS : PRIO_BITS;
    localparam int HW = spq_pkg::ID_W;
    localparam int OW = spq_pkg::OCC_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND_RD  = 4'd1;
    localparam logic [3:0] S_FIND_CMP = 4'd2;
    localparam logic [3:0] S_REM_RD   = 4'd3;
    localparam logic [3:0] S_REM_WR   = 4'd4;
    localparam logic [3:0] S_INS_RD   = 4'd5;
    localparam logic [3:0] S_INS_CMP  = 4'd6;
    localparam logic [3:0] S_NUD_RD   = 4'd7;
    localparam logic [3:0] S_NUD_WR0  = 4'd8;
    localparam logic [3:0] S_NUD_WR1  = 4'd9;
    localparam logic [3:0] S_HEAD_RD  = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [spq_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [ID_BITS-1:0]           id_reg, id_next;
    logic [PRIO_BITS-1:0]         prio_reg, prio_next;
    logic [spq_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [KW-1:0]        cmp_a, cmp_b;
    logic                 cmp_hit;
    logic                 idx_last;
    logic                 is_full;

    assign rd_id    = ram_rd_data[EW-1 -: ID_BITS];
    assign rd_prio  = ram_rd_data[PRIO_BITS-1:0];
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign is_full  = (count_reg == CW'(DEPTH));

    // The one compare unit: id match while searching, priority order while inserting.
    always_comb begin
        if (state_reg == S_FIND_CMP) begin
            cmp_a   = KW'(rd_id);
            cmp_b   = KW'(id_reg);
            cmp_hit = (cmp_a == cmp_b);
        end else begin
            cmp_a   = KW'(rd_prio);
            cmp_b   = KW'(prio_reg);
            cmp_hit = (cmp_a > cmp_b);
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        func_next   = func_reg;
        id_next     = id_reg;
        prio_next   = prio_reg;
        status_next = status_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    func_next   = cmd.func;
                    id_next     = ID_BITS'(cmd.item_id);
                    prio_next   = PRIO_BITS'(cmd.item_priority);
                    status_next = spq_pkg::STATUS_OK;
                    idx_next    = '0;
                    case (cmd.func)
                        spq_pkg::FUNC_ENQUEUE: begin
                            state_next = (count_reg == '0) ? S_INS_RD : S_FIND_RD;
                        end
                        spq_pkg::FUNC_DEQUEUE: begin
                            if (count_reg == '0) begin
                                status_next = spq_pkg::STATUS_EMPTY;
                                state_next  = S_HEAD_RD;
                            end else begin
                                state_next = S_REM_RD;
                            end
                        end
                        spq_pkg::FUNC_FRONT: begin
                            if (count_reg == '0) begin
                                status_next = spq_pkg::STATUS_EMPTY;
                            end
                            state_next = S_HEAD_RD;
                        end
                        spq_pkg::FUNC_NUDGE: begin
                            if (count_reg == '0) begin
                                status_next = spq_pkg::STATUS_NOT_FOUND;
                                state_next  = S_HEAD_RD;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        spq_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                            state_next = S_HEAD_RD;
                        end
                        default: begin
                            state_next = S_HEAD_RD;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                ram_rd_en  = 1'b1;
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (cmp_hit) begin
                    if (func_reg == spq_pkg::FUNC_ENQUEUE) begin
                        state_next = S_REM_RD;
                    end else if (idx_reg == '0) begin
                        state_next = S_HEAD_RD;
                    end else begin
                        state_next = S_NUD_RD;
                    end
                end else if (idx_last) begin
                    if (func_reg != spq_pkg::FUNC_ENQUEUE) begin
                        status_next = spq_pkg::STATUS_NOT_FOUND;
                        state_next  = S_HEAD_RD;
                    end else if (is_full) begin
                        status_next = spq_pkg::STATUS_FULL;
                        state_next  = S_HEAD_RD;
                    end else begin
                        idx_next   = AW'(count_reg);
                        state_next = S_INS_RD;
                    end
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_FIND_RD;
                end
            end
            // Close the gap left at idx by moving the tail down one slot at a time.
            S_REM_RD: begin
                if (idx_last) begin
                    count_next = count_reg - CW'(1);
                    if (func_reg == spq_pkg::FUNC_ENQUEUE) begin
                        idx_next   = AW'(count_reg - CW'(1));
                        state_next = S_INS_RD;
                    end else begin
                        state_next = S_HEAD_RD;
                    end
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg + AW'(1);
                    state_next  = S_REM_WR;
                end
            end
            S_REM_WR: begin
                ram_wr_en  = 1'b1;
                idx_next   = idx_reg + AW'(1);
                state_next = S_REM_RD;
            end
            // Walk down from the tail, shifting up every entry of strictly higher
            // priority, so that equal priorities keep their arrival order.
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = {id_reg, prio_reg};
                    count_next  = count_reg + CW'(1);
                    state_next  = S_HEAD_RD;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_reg - AW'(1);
                    state_next  = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_wr_en = 1'b1;
                if (cmp_hit) begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = S_INS_RD;
                end else begin
                    ram_wr_data = {id_reg, prio_reg};
                    count_next  = count_reg + CW'(1);
                    state_next  = S_HEAD_RD;
                end
            end
            S_NUD_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_reg - AW'(1);
                state_next  = S_NUD_WR0;
            end
            S_NUD_WR0: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg - AW'(1);
                ram_wr_data = {id_reg, rd_prio};
                state_next  = S_NUD_WR1;
            end
            S_NUD_WR1: begin
                // The predecessor word still sits in the read register.
                ram_wr_en  = 1'b1;
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status     = status_reg;
        res.head_valid = (count_reg != '0);
        res.head_id    = (count_reg != '0) ? HW'(rd_id) : '0;
        res.occupancy  = OW'(count_reg);
    end

    assign cmd_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        func_reg   <= func_next;
        id_reg     <= id_next;
        prio_reg   <= prio_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

@@ sv/stable_priority_queue_with_nudge.sv @@
`default_nettype none

// Sorted priority queue of (id, priority) entries, lowest priority at the head.
// Input channel s_*: one word per operation; s_tuser carries the operation
// (enqueue, dequeue, front, nudge, clear) and s_tdata the id and priority.
// Result channel m_*: exactly one word per operation with status, head
// valid, head id and occupancy after the operation.
// One operation runs at a time in a sequencer around a slot memory with one
// read and one write port and one compare unit; s_tready is high only while
// it is idle. Front, clear, unused codes and the empty cases go straight to
// the head read; other operations first visit slots one at a time: a search
// visits slots up to the match, removal visits the slots behind the removed
// entry, insertion visits the slots of higher priority, and a nudge adds a
// read and two writes. A re-enqueue in a full store of DEPTH entries takes
// the longest.
// Results leave through an output register, so the next operation is
// accepted while a result waits; if the receiver stalls with m_tready low,
// the following result is held inside until the register frees up.
// Synchronous active-low reset empties the queue and drops any pending
// result; slot contents are not cleared and need no clearing pass.
module stable_priority_queue_with_nudge #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] item_id, [31:16] item_priority
    input  wire logic [spq_pkg::S_DATA_W-1:0]  s_tdata,
    // [2:0] func
    input  wire logic [spq_pkg::FUNC_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [2] head_valid, [18:3] head_id, [23:19] occupancy
    output logic [spq_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = ID_BITS + PRIO_BITS;

    spq_pkg::cmd_t    cmd;
    spq_pkg::result_t res;
    logic             cmd_ready;
    logic             res_valid;
    logic             out_free;
    logic             m_valid_reg;
    logic [spq_pkg::M_DATA_W-1:0] m_data_reg;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_data;

    assign cmd.func          = s_tuser;
    assign cmd.item_id       = s_tdata[15:0];
    assign cmd.item_priority = s_tdata[31:16];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = cmd_ready;

    spq_seq #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_tvalid),
        .cmd         (cmd),
        .cmd_ready   (cmd_ready),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    spq_slot_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= {res.occupancy, res.head_id, res.head_valid, res.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ sv/spq_checker.sv @@
`default_nettype none

module spq_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [spq_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int HV  = spq_pkg::M_HV_BIT;
    localparam int HL  = spq_pkg::M_HEAD_LSB;
    localparam int OL  = spq_pkg::M_OCC_LSB;
    localparam int HWD = spq_pkg::ID_W;
    localparam int OWD = spq_pkg::OCC_W;

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // Only one operation is in flight: input is refused right after acceptance.
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while an operation runs");

    // Head valid agrees with occupancy, and an empty queue shows head id zero.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[HV] == (m_tdata[OL +: OWD] != '0)))
        else $error("head valid disagrees with occupancy");

    a_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[HV]) |-> (m_tdata[HL +: HWD] == '0))
        else $error("empty queue with nonzero head id");

    // An empty status leaves the queue empty.
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == spq_pkg::STATUS_EMPTY)) |-> !m_tdata[HV])
        else $error("empty status with a valid head");

endmodule

bind stable_priority_queue_with_nudge spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/stable_priority_queue_with_nudge_tb.sv @@
`timescale 1ns / 100ps

module stable_priority_queue_with_nudge_tb;

    localparam int NSLOT = spq_pkg::DEPTH_DEF;
    localparam int POOL_SIZE = 24;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int FW = spq_pkg::FUNC_W;
    localparam int IW = spq_pkg::ID_W;
    localparam int PW = spq_pkg::PRIO_W;
    localparam logic [FW-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FW-1:0] FUNC_UNUSED_LAST  = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [spq_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic [FW-1:0]                  s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [spq_pkg::M_DATA_W-1:0]   m_tdata;

    // Mirror of the queue contents, head in entry 0.
    logic [IW-1:0]     queue_ids [NSLOT];
    logic [PW-1:0]     queue_prios [NSLOT];
    int                queue_count = 0;

    spq_pkg::result_t  expected_results [$];
    int unsigned       error_count = 0;
    bit                steady = 1'b0;
    int unsigned       hold_off_left = 0;
    logic [IW-1:0]     id_pool [POOL_SIZE];

    stable_priority_queue_with_nudge dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int locate_id(input logic [IW-1:0] id);
        for (int i = 0; i < queue_count; i++) begin
            if (queue_ids[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < queue_count; i++) begin
            queue_ids[i] = queue_ids[i + 1];
            queue_prios[i] = queue_prios[i + 1];
        end
        queue_count--;
    endfunction

    // A new entry goes behind every entry of lower or equal priority.
    function automatic void insert_by_priority(input logic [IW-1:0] id,
                                               input logic [PW-1:0] prio);
        int pos;
        pos = 0;
        while (pos < queue_count && queue_prios[pos] <= prio) begin
            pos++;
        end
        for (int i = queue_count; i > pos; i--) begin
            queue_ids[i] = queue_ids[i - 1];
            queue_prios[i] = queue_prios[i - 1];
        end
        queue_ids[pos] = id;
        queue_prios[pos] = prio;
        queue_count++;
    endfunction

    function automatic spq_pkg::result_t apply_operation(input logic [FW-1:0] func,
                                                         input logic [IW-1:0] id,
                                                         input logic [PW-1:0] prio);
        spq_pkg::result_t res;
        int               pos;
        logic [IW-1:0]    prev_id;
        res.status = spq_pkg::STATUS_OK;
        case (func)
            spq_pkg::FUNC_ENQUEUE: begin
                pos = locate_id(id);
                if (pos >= 0) begin
                    drop_entry(pos);
                    insert_by_priority(id, prio);
                end else if (queue_count >= NSLOT) begin
                    res.status = spq_pkg::STATUS_FULL;
                end else begin
                    insert_by_priority(id, prio);
                end
            end
            spq_pkg::FUNC_DEQUEUE: begin
                if (queue_count == 0) begin
                    res.status = spq_pkg::STATUS_EMPTY;
                end else begin
                    drop_entry(0);
                end
            end
            spq_pkg::FUNC_FRONT: begin
                if (queue_count == 0) begin
                    res.status = spq_pkg::STATUS_EMPTY;
                end
            end
            spq_pkg::FUNC_NUDGE: begin
                pos = locate_id(id);
                if (pos < 0) begin
                    res.status = spq_pkg::STATUS_NOT_FOUND;
                end else if (pos > 0) begin
                    // The moved entry inherits its predecessor's priority, so both match.
                    prev_id = queue_ids[pos - 1];
                    queue_ids[pos - 1] = queue_ids[pos];
                    queue_ids[pos] = prev_id;
                    queue_prios[pos] = queue_prios[pos - 1];
                end
            end
            spq_pkg::FUNC_CLEAR: begin
                queue_count = 0;
            end
            default: begin
            end
        endcase
        res.head_valid = (queue_count > 0);
        res.head_id = (queue_count > 0) ? queue_ids[0] : '0;
        res.occupancy = spq_pkg::OCC_W'(queue_count);
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IW-1:0] choose_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (queue_count > 0 && r < 35) begin
            return queue_ids[$urandom_range(0, queue_count - 1)];
        end else if (r < 85) begin
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return IW'($urandom);
    endfunction

    function automatic logic [PW-1:0] choose_priority();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return PW'(100 * $urandom_range(1, 4));
        end else if (r < 35) begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return PW'($urandom);
    endfunction

    // Offers one word and returns at the edge that accepts it, with s_tvalid
    // still high so that a following word can go out without a gap.
    task automatic send_op(input logic [FW-1:0] func, input logic [IW-1:0] id,
                           input logic [PW-1:0] prio);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {prio, id};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(apply_operation(func, id, prio));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic random_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_op(spq_pkg::FUNC_ENQUEUE, choose_id(), choose_priority());
        end else if (r < 60) begin
            send_op(spq_pkg::FUNC_DEQUEUE, IW'($urandom), PW'($urandom));
        end else if (r < 66) begin
            send_op(spq_pkg::FUNC_FRONT, IW'($urandom), PW'($urandom));
        end else if (r < 88) begin
            send_op(spq_pkg::FUNC_NUDGE, choose_id(), PW'($urandom));
        end else if (r < 89) begin
            send_op(spq_pkg::FUNC_CLEAR, IW'($urandom), PW'($urandom));
        end else if (r < 92) begin
            send_op(FW'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                    IW'($urandom), PW'($urandom));
        end else begin
            send_op(spq_pkg::FUNC_ENQUEUE, IW'($urandom), PW'($urandom));
        end
    endtask

    task automatic test_empty_queue();
        send_op(spq_pkg::FUNC_DEQUEUE, '0, '0);
        send_op(spq_pkg::FUNC_FRONT, '1, '1);
        send_op(spq_pkg::FUNC_NUDGE, 16'h1234, '0);
        send_op(FUNC_UNUSED_FIRST, '1, '0);
        send_op(FUNC_UNUSED_LAST, '0, '1);
        settle();
    endtask

    // Fills the store with extreme ids and priorities and with runs of equal
    // priority, then overflows it, re-enqueues and nudges while it is full.
    task automatic test_fill_and_overflow();
        send_op(spq_pkg::FUNC_ENQUEUE, 16'h0000, 16'hFFFF);
        send_op(spq_pkg::FUNC_ENQUEUE, 16'hFFFF, 16'h0000);
        for (int i = 0; i < NSLOT - 2; i++) begin
            send_op(spq_pkg::FUNC_ENQUEUE, IW'(16'hA500 + i),
                    (i % 3 == 0) ? PW'(500) : PW'(1000 - i));
        end
        send_op(spq_pkg::FUNC_ENQUEUE, 16'h7777, 16'h0001);
        send_op(spq_pkg::FUNC_ENQUEUE, 16'hA503, 16'h0000);
        send_op(spq_pkg::FUNC_NUDGE, 16'hA503, '0);
        send_op(spq_pkg::FUNC_NUDGE, 16'hA503, '1);
        send_op(spq_pkg::FUNC_DEQUEUE, '0, '0);
        send_op(spq_pkg::FUNC_CLEAR, '0, '0);
        settle();
    endtask

    // The receiver stops taking words while the sender keeps offering, so
    // the block fills its output stage and has to hold back its input.
    task automatic test_receiver_hold_off();
        steady = 1'b1;
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (40) random_op();
        settle();
        steady = 1'b0;
    endtask

    task automatic test_random_ops(input int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            steady = ($urandom_range(0, 5) == 0);
            repeat (100) begin
                random_op();
                sent++;
            end
            if ($urandom_range(0, 1) == 1) begin
                while (queue_count > 0) begin
                    send_op(spq_pkg::FUNC_DEQUEUE, IW'($urandom), PW'($urandom));
                    sent++;
                end
                send_op(spq_pkg::FUNC_DEQUEUE, IW'($urandom), PW'($urandom));
                sent++;
            end
        end
        steady = 1'b0;
        settle();
    endtask

    // Receiver side of the result channel.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (m_tready && m_tvalid) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        spq_pkg::result_t want;
        spq_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[spq_pkg::STATUS_W-1:0];
            got.head_valid = m_tdata[spq_pkg::M_HV_BIT];
            got.head_id = m_tdata[spq_pkg::M_HEAD_LSB +: IW];
            got.occupancy = m_tdata[spq_pkg::M_OCC_LSB +: spq_pkg::OCC_W];
            if (expected_results.size() == 0) begin
                $display("%0t: result word with none expected, got %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.head_valid !== want.head_valid) begin
                    $display("%0t: head_valid expected %0d, got %0d",
                             $time, want.head_valid, got.head_valid);
                    error_count++;
                end
                if (got.head_id !== want.head_id) begin
                    $display("%0t: head_id expected %h, got %h",
                             $time, want.head_id, got.head_id);
                    error_count++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d, got %0d",
                             $time, want.occupancy, got.occupancy);
                    error_count++;
                end
            end
        end
    end

    initial begin
        // A small pool of ids makes repeats and hits on stored entries common.
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            id_pool[i] = IW'($urandom);
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_fill_and_overflow();
        test_receiver_hold_off();
        test_random_ops(1540);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ stable_priority_queue_with_nudge.f @@
sv/spq_pkg.sv
sv/spq_slot_ram.sv
sv/spq_seq.sv
sv/stable_priority_queue_with_nudge.sv
sv/spq_checker.sv
verif/stable_priority_queue_with_nudge_tb.sv
